// File: sv/ktl_pkg.sv
package ktl_pkg;

    localparam int POS_BITS = 16;
    localparam int LEN_MAX_I = (POS_BITS < 16) ? ((1 << POS_BITS) - 1) : 65535;
    localparam logic [15:0] LEN_MAX = LEN_MAX_I[15:0];
    localparam logic [15:0] LEN_TWO = (LEN_MAX_I < 2) ? LEN_MAX : 16'd2;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_INT  = 3'd1,
        M_FRAC = 3'd2,
        M_WORD = 3'd3,
        M_PEQ  = 3'd4,
        M_PLT  = 3'd5,
        M_PGT  = 3'd6
    } mode_t;

    localparam logic [5:0] K_END   = 6'd0;
    localparam logic [5:0] K_ERR   = 6'd1;
    localparam logic [5:0] K_INT   = 6'd2;
    localparam logic [5:0] K_FLOAT = 6'd3;
    localparam logic [5:0] K_ID    = 6'd4;
    localparam logic [5:0] K_KW0   = 6'd5;
    localparam logic [5:0] K_OP0   = 6'd25;
    localparam logic [5:0] K_ASSIGN = 6'd31;
    localparam logic [5:0] K_LT    = 6'd34;
    localparam logic [5:0] K_GT    = 6'd35;
    localparam logic [5:0] K_EQ    = 6'd39;
    localparam logic [5:0] K_LE    = 6'd40;
    localparam logic [5:0] K_GE    = 6'd41;

    // One classified item: up to two tokens; the word token is resolved later.
    typedef struct packed {
        logic        t0_valid;
        logic        t0_word;
        logic [5:0]  t0_kind;
        logic [15:0] t0_start;
        logic [15:0] t0_len;
        logic [63:0] t0_buf;
        logic [3:0]  t0_cnt;
        logic        t1_valid;
        logic [5:0]  t1_kind;
        logic [15:0] t1_start;
        logic [15:0] t1_len;
    } job_t;

    function automatic logic [63:0] kw_pack(input int k);
        logic [63:0] p;
        p = 64'd0;
        case (k)
            0:  p = 64'h0000_0074_6e69_7270; // print
            1:  p = 64'h0000_0000_0000_6669; // if
            2:  p = 64'h0000_0000_6e65_6874; // then
            3:  p = 64'h0000_0000_6573_6c65; // else
            4:  p = 64'h0000_0066_6964_6e65; // endif
            5:  p = 64'h0000_0070_7865_6669; // ifexp
            6:  p = 64'h0000_0065_6c69_6877; // while
            7:  p = 64'h656c_6968_7764_6e65; // endwhile
            8:  p = 64'h0000_0000_0000_6f64; // do
            9:  p = 64'h0000_0000_0072_6f66; // for
            10: p = 64'h0000_726f_6664_6e65; // endfor
            11: p = 64'h0000_0000_0072_6176; // var
            12: p = 64'h0000_0000_6575_7274; // true
            13: p = 64'h0000_0065_736c_6166; // false
            14: p = 64'h0000_0000_006e_7566; // fun
            15: p = 64'h0000_6e75_6664_6e65; // endfun
            16: p = 64'h0000_6e72_7574_6572; // return
            17: p = 64'h0000_0000_0074_6e49; // Int
            18: p = 64'h0000_0074_616f_6c46; // Float
            19: p = 64'h006e_6c74_6e69_7270; // println
            default: p = 64'd0;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] n;
        case (k)
            1, 8:           n = 4'd2;
            9, 11, 14, 17:  n = 4'd3;
            2, 3, 12:       n = 4'd4;
            0, 4, 5, 6, 13, 18: n = 4'd5;
            10, 15, 16:     n = 4'd6;
            19:             n = 4'd7;
            7:              n = 4'd8;
            default:        n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// File: sv/keyword_token_lexer_unit.sv
// Flow: a character is classified into a job register in the front, and that job is then
// pushed into the back's job queue; its first token is offered from the queue head.
// Throughput: one character per cycle unless out_ready back-pressure stalls it; an item
// that yields two tokens sends them one after the other. The two-entry job queue absorbs
// short bursts of these, and a sustained run of them holds back the input.
// Reset: rst_n asynchronously clears scan mode, offsets, word buffer and the queue.
module keyword_token_lexer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  kind,
    output logic [15:0] start_res,
    output logic [15:0] length,
    output logic        last_of_run
);

    logic          job_valid, job_ready;
    ktl_pkg::job_t job;

    ktl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .is_end    (is_end),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ktl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .start_res   (start_res),
        .length      (length),
        .last_of_run (last_of_run)
    );

endmodule

// File: sv/ktl_front.sv
module ktl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           ch,
    input  logic                 is_end,
    output logic                 job_valid,
    input  logic                 job_ready,
    output ktl_pkg::job_t        job
);

    ktl_pkg::mode_t                 mode_reg, mode_next;
    logic [ktl_pkg::POS_BITS-1:0]   start_reg, start_next;
    logic [ktl_pkg::POS_BITS-1:0]   pos_reg, pos_next;
    logic [63:0]                    buf_reg, buf_next;
    logic [3:0]                     cnt_reg, cnt_next;
    logic [15:0]                    run_reg, run_next;
    logic                           jv_reg;
    ktl_pkg::job_t                  job_reg, job_nx;

    logic digit, alpha, space, take;
    logic [15:0] run_inc, pos16, st16;
    logic [5:0]  op_kind;
    logic        op_hit;

    assign in_ready  = !jv_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    assign digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign alpha = ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a));
    assign space = (ch == 8'h20) || (ch == 8'h0a) || (ch == 8'h0d) || (ch == 8'h09);
    assign run_inc = (run_reg < ktl_pkg::LEN_MAX) ? run_reg + 16'd1 : run_reg;
    assign pos16 = 16'(pos_reg);
    assign st16  = 16'(start_reg);

    always_comb
    begin
        op_hit  = 1'b1;
        op_kind = ktl_pkg::K_ERR;
        case (ch)
            8'h2b: op_kind = ktl_pkg::K_OP0 + 6'd0;
            8'h2d: op_kind = ktl_pkg::K_OP0 + 6'd1;
            8'h2a: op_kind = ktl_pkg::K_OP0 + 6'd2;
            8'h2f: op_kind = ktl_pkg::K_OP0 + 6'd3;
            8'h28: op_kind = ktl_pkg::K_OP0 + 6'd4;
            8'h29: op_kind = ktl_pkg::K_OP0 + 6'd5;
            8'h3b: op_kind = ktl_pkg::K_OP0 + 6'd7;
            8'h2c: op_kind = ktl_pkg::K_OP0 + 6'd8;
            8'h7b: op_kind = ktl_pkg::K_OP0 + 6'd11;
            8'h7d: op_kind = ktl_pkg::K_OP0 + 6'd12;
            8'h3a: op_kind = ktl_pkg::K_OP0 + 6'd13;
            default: op_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        logic flush_now;
        logic go_idle;
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg + {{(ktl_pkg::POS_BITS-1){1'b0}}, 1'b1};
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        job_nx     = '0;
        flush_now  = 1'b0;
        go_idle    = 1'b0;

        if (is_end)
        begin
            flush_now  = 1'b1;
            mode_next  = ktl_pkg::M_IDLE;
            start_next = '0;
            pos_next   = '0;
            buf_next   = '0;
            cnt_next   = '0;
            run_next   = '0;
        end
        else
        begin
            case (mode_reg)
                ktl_pkg::M_INT:
                begin
                    if (digit)
                        run_next = run_inc;
                    else if (ch == 8'h2e)
                    begin
                        run_next  = run_inc;
                        mode_next = ktl_pkg::M_FRAC;
                    end
                    else
                    begin
                        flush_now = 1'b1;
                        go_idle   = 1'b1;
                    end
                end
                ktl_pkg::M_FRAC:
                begin
                    if (digit)
                        run_next = run_inc;
                    else if (ch == 8'h66 || ch == 8'h46)
                    begin
                        job_nx.t0_valid = 1'b1;
                        job_nx.t0_kind  = ktl_pkg::K_FLOAT;
                        job_nx.t0_start = st16;
                        job_nx.t0_len   = run_inc;
                        run_next        = run_inc;
                        mode_next       = ktl_pkg::M_IDLE;
                    end
                    else
                    begin
                        flush_now = 1'b1;
                        go_idle   = 1'b1;
                    end
                end
                ktl_pkg::M_WORD:
                begin
                    if (digit || alpha)
                    begin
                        run_next = run_inc;
                        if (cnt_reg < 4'd8)
                        begin
                            buf_next = buf_reg | (64'(ch) << {cnt_reg[2:0], 3'b000});
                            cnt_next = cnt_reg + 4'd1;
                        end
                        else
                            cnt_next = 4'd9;
                    end
                    else
                    begin
                        flush_now = 1'b1;
                        go_idle   = 1'b1;
                    end
                end
                ktl_pkg::M_PEQ, ktl_pkg::M_PLT, ktl_pkg::M_PGT:
                begin
                    if (ch == 8'h3d)
                    begin
                        job_nx.t0_valid = 1'b1;
                        job_nx.t0_kind  = (mode_reg == ktl_pkg::M_PEQ) ? ktl_pkg::K_EQ :
                                          (mode_reg == ktl_pkg::M_PLT) ? ktl_pkg::K_LE :
                                          ktl_pkg::K_GE;
                        job_nx.t0_start = st16;
                        job_nx.t0_len   = ktl_pkg::LEN_TWO;
                        mode_next       = ktl_pkg::M_IDLE;
                    end
                    else
                    begin
                        flush_now = 1'b1;
                        go_idle   = 1'b1;
                    end
                end
                default: go_idle = 1'b1;
            endcase
        end

        if (flush_now)
        begin
            job_nx.t0_start = st16;
            job_nx.t0_len   = run_reg;
            job_nx.t0_buf   = buf_reg;
            job_nx.t0_cnt   = cnt_reg;
            case (mode_reg)
                ktl_pkg::M_INT:
                begin
                    job_nx.t0_valid = 1'b1;
                    job_nx.t0_kind  = ktl_pkg::K_INT;
                end
                ktl_pkg::M_FRAC:
                begin
                    job_nx.t0_valid = 1'b1;
                    job_nx.t0_kind  = ktl_pkg::K_FLOAT;
                end
                ktl_pkg::M_WORD:
                begin
                    job_nx.t0_valid = 1'b1;
                    job_nx.t0_word  = 1'b1;
                end
                ktl_pkg::M_PEQ:
                begin
                    job_nx.t0_valid = 1'b1; job_nx.t0_kind = ktl_pkg::K_ASSIGN;
                    job_nx.t0_len = 16'd1;
                end
                ktl_pkg::M_PLT:
                begin
                    job_nx.t0_valid = 1'b1; job_nx.t0_kind = ktl_pkg::K_LT;
                    job_nx.t0_len = 16'd1;
                end
                ktl_pkg::M_PGT:
                begin
                    job_nx.t0_valid = 1'b1; job_nx.t0_kind = ktl_pkg::K_GT;
                    job_nx.t0_len = 16'd1;
                end
                default: job_nx.t0_valid = 1'b0;
            endcase
        end

        if (is_end)
        begin
            job_nx.t1_valid = 1'b1;
            job_nx.t1_kind  = ktl_pkg::K_END;
        end

        // A character that ends a token, or arrives with none pending, starts anew.
        if (go_idle)
        begin
            mode_next = ktl_pkg::M_IDLE;
            if (!space)
            begin
                start_next = pos_reg;
                run_next   = 16'd1;
                if (digit)
                    mode_next = ktl_pkg::M_INT;
                else if (alpha)
                begin
                    mode_next = ktl_pkg::M_WORD;
                    buf_next  = 64'(ch);
                    cnt_next  = 4'd1;
                end
                else if (ch == 8'h3d)
                    mode_next = ktl_pkg::M_PEQ;
                else if (ch == 8'h3c)
                    mode_next = ktl_pkg::M_PLT;
                else if (ch == 8'h3e)
                    mode_next = ktl_pkg::M_PGT;
                else
                begin
                    job_nx.t1_valid = 1'b1;
                    job_nx.t1_kind  = op_hit ? op_kind : ktl_pkg::K_ERR;
                    job_nx.t1_start = pos16;
                    job_nx.t1_len   = 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ktl_pkg::M_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            buf_reg   <= '0;
            cnt_reg   <= '0;
            run_reg   <= '0;
            jv_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                pos_reg   <= pos_next;
                buf_reg   <= buf_next;
                cnt_reg   <= cnt_next;
                run_reg   <= run_next;
                jv_reg    <= job_nx.t0_valid || job_nx.t1_valid;
            end
            else if (job_ready)
                jv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_nx;
    end

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= ktl_pkg::LEN_MAX) else $error("run length past limit");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd9) else $error("word count out of range");
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        jv_reg |-> (job_reg.t0_valid || job_reg.t1_valid)) else $error("empty job");

endmodule

// File: sv/ktl_back.sv
module ktl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  ktl_pkg::job_t   job,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [5:0]      kind,
    output logic [15:0]     start_res,
    output logic [15:0]     length,
    output logic            last_of_run
);

    // Two-entry queue of classified jobs; each job drains one token a cycle while out_ready is high.
    ktl_pkg::job_t q_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    n_reg;
    logic          half_reg;   // first token of head job already sent
    logic [5:0]    wkind;
    ktl_pkg::job_t head;
    logic          push, pop, fire, on_t0;

    assign head      = q_reg[rp_reg];
    assign job_ready = (n_reg != 2'd2);
    assign push      = job_valid && job_ready;
    assign out_valid = (n_reg != 2'd0);
    assign fire      = out_valid && out_ready;
    assign on_t0     = head.t0_valid && !half_reg;
    assign pop       = fire && (!on_t0 || !head.t1_valid);

    always_comb
    begin
        wkind = ktl_pkg::K_ID;
        if (head.t0_cnt <= 4'd8)
        begin
            for (int k = 0; k < 20; k++)
            begin
                if (head.t0_cnt == ktl_pkg::kw_len(k) && head.t0_buf == ktl_pkg::kw_pack(k))
                    wkind = ktl_pkg::K_KW0 + 6'(k);
            end
        end
    end

    always_comb
    begin
        if (on_t0)
        begin
            kind        = head.t0_word ? wkind : head.t0_kind;
            start_res   = head.t0_start;
            length      = head.t0_len;
            last_of_run = !head.t1_valid;
        end
        else
        begin
            kind        = head.t1_kind;
            start_res   = head.t1_start;
            length      = head.t1_len;
            last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            n_reg    <= 2'd0;
            half_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
            begin
                rp_reg   <= !rp_reg;
                half_reg <= 1'b0;
            end
            else if (fire)
                half_reg <= 1'b1;
            n_reg <= n_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job;
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 2'd2) else $error("queue overflow");
    a_half: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (n_reg != 2'd0)) else $error("half flag with empty queue");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg == 2'd0 || n_reg == 2'd2) |-> (wp_reg == rp_reg)) else $error("pointer slip");

endmodule
